[sv/hrhm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrhm_pkg: shared types and constants of the histogram marker
// table geometry, item kinds, table operations and the cell stream struct
// ----------------------------------------------------------------------------
package hrhm_pkg;

  localparam int ADDR_W     = 12;               // table address width
  localparam int DEPTH      = 1 << ADDR_W;      // table entries
  localparam int CNT_W      = 32;               // bin counter width
  localparam int BINS_W     = 5;                // bins_in_use register width
  localparam int BOUND_W    = 4;                // bits per lower bound
  localparam int BOUNDS_W   = 12;               // lower_bounds field width
  localparam int BOUND_DIMS = BOUNDS_W / BOUND_W;
  localparam int MAX_BINS   = 16;               // cap on the radix
  localparam int POS_W      = $clog2(MAX_BINS); // per-dimension position
  localparam int BINS_RESET = 16;

  typedef enum logic [1:0] {
    KIND_INC   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    TOP_NONE     = 3'd0,
    TOP_READ     = 3'd1,
    TOP_BUMP     = 3'd2,
    TOP_CLR_MARK = 3'd3,
    TOP_CLR_ALL  = 3'd4
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e           op;
    logic [ADDR_W-1:0] addr;
  } tbl_req_t;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] addr;
  } cell_t;

endpackage
`default_nettype wire

[sv/hyper_rectangle_histogram_marker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// throughput: one transaction at a time; busy_o stays high until done_o, the
//   cell walk makes one read-modify-write per cycle through the table memory
// reset: a clearing pass over all table entries zeroes counters and marks, busy_o high
// results: done_o is a one-cycle strobe, the receiver cannot stall
// ----------------------------------------------------------------------------
// hyper_rectangle_histogram_marker_unit: marked histogram over a box of bins
// top level with command handshake, config register and the sequencer that
// drives the cell walker and the counter table
// ----------------------------------------------------------------------------
module hyper_rectangle_histogram_marker_unit #(
  parameter int RANK = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command channel
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      kind_i,
  input  logic [hrhm_pkg::BOUNDS_W-1:0]   lower_bounds_i,
  input  logic [hrhm_pkg::ADDR_W-1:0]     read_address_i,
  // result strobe
  output logic                            done_o,
  output logic [hrhm_pkg::CNT_W-1:0]      count_o,
  output logic                            marked_o,
  output logic                            bad_bounds_o,
  // config write channel, bins_in_use
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hrhm_pkg::BINS_W-1:0]     cfg_data_i
);
  import hrhm_pkg::*;

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_CLEAR = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic [BINS_W-1:0] bins_q;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              marked_q, marked_d;
  logic              bad_q, bad_d;

  logic [BINS_W-1:0]            radix;
  logic [RANK-1:0][POS_W-1:0]   starts;
  logic [RANK-1:0]              over;
  logic                         bad_in;
  logic                         accept;
  logic                         go;
  tbl_req_t                     req;
  cell_t                        walk_cell;
  logic [CNT_W-1:0]             rd_cnt;
  logic                         rd_mark;

  // config register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q <= BINS_W'(BINS_RESET);
    end else if (cfg_valid_i) begin
      bins_q <= cfg_data_i;
    end
  end

  // effective radix is capped at the table's bins per dimension
  assign radix = (bins_q > BINS_W'(MAX_BINS)) ? BINS_W'(MAX_BINS) : bins_q;

  // lower bounds per dimension; dimensions past the field start at zero
  for (genvar d = 0; d < RANK; d++) begin : g_start
    if (d < BOUND_DIMS) begin : g_field
      assign starts[d] = POS_W'(lower_bounds_i[d*BOUND_W +: BOUND_W]);
    end else begin : g_zero
      assign starts[d] = '0;
    end
    assign over[d] = ({1'b0, starts[d]} >= radix);
  end

  assign bad_in = |over;
  assign accept = start_i && !busy_o;
  assign go     = accept && (kind_i == KIND_INC) && !bad_in;

  // sequencer
  always_comb begin
    state_d  = state_q;
    sweep_d  = sweep_q;
    done_d   = 1'b0;
    count_d  = '0;
    marked_d = 1'b0;
    bad_d    = 1'b0;
    req.op   = TOP_NONE;
    req.addr = sweep_q;
    unique case (state_q)
      ST_INIT: begin
        // power-up clearing pass over counters and marks
        req.op  = TOP_CLR_ALL;
        sweep_d = sweep_q + 1'b1;
        if (&sweep_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KIND_INC: begin
              if (bad_in) begin
                done_d = 1'b1;
                bad_d  = 1'b1;
              end else begin
                state_d = ST_WALK;
              end
            end
            KIND_CLEAR: begin
              state_d = ST_CLEAR;
              sweep_d = '0;
            end
            KIND_READ: begin
              req.op   = TOP_READ;
              req.addr = read_address_i;
              state_d  = ST_READ;
            end
            default: begin
              // unused kind: empty result
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_WALK: begin
        // weights and base address first, then one cell per cycle
        req.addr = walk_cell.addr;
        if (walk_cell.valid) begin
          req.op = TOP_BUMP;
          if (walk_cell.last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // last cell write lands in this cycle
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_CLEAR: begin
        req.op  = TOP_CLR_MARK;
        sweep_d = sweep_q + 1'b1;
        if (&sweep_q) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        done_d   = 1'b1;
        count_d  = rd_cnt;
        marked_d = rd_mark;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      sweep_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_d) begin
      count_q  <= count_d;
      marked_q <= marked_d;
      bad_q    <= bad_d;
    end
  end

  hrhm_addr_gen #(
    .RANK (RANK)
  ) u_addr_gen (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (go),
    .starts_i (starts),
    .radix_i  (radix),
    .cell_o   (walk_cell)
  );

  hrhm_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_cnt_o  (rd_cnt),
    .rd_mark_o (rd_mark)
  );

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign count_o      = count_q;
  assign marked_o     = marked_q;
  assign bad_bounds_o = bad_q;

  // every transaction finishes back in idle
  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while still busy");

  // the walker only runs under the walk state
  a_cells_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_cell.valid |-> (state_q == ST_WALK))
    else $error("cell issued outside the walk");

  // the power-up clearing pass runs once
  a_init_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_INIT) |=> (state_q != ST_INIT))
    else $error("clearing pass re-entered");

endmodule
`default_nettype wire

[sv/hrhm_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrhm_table: counter and fill mark memories
// registered read, read-modify-write stage for bumps with forwarding,
// single-entry clear writes for the sweeps
// ----------------------------------------------------------------------------
module hrhm_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hrhm_pkg::tbl_req_t        req_i,
  output logic [hrhm_pkg::CNT_W-1:0] rd_cnt_o,
  output logic                      rd_mark_o
);
  import hrhm_pkg::*;

  logic [CNT_W-1:0] cnt_mem  [DEPTH];
  logic             mark_mem [DEPTH];

  logic [CNT_W-1:0]  rd_cnt_q;
  logic              rd_mark_q;
  tbl_op_e           op_q;
  logic [ADDR_W-1:0] addr_q;
  logic              fwd_valid_q;
  logic [ADDR_W-1:0] fwd_addr_q;
  logic [CNT_W-1:0]  fwd_cnt_q;

  logic              bump;
  logic              hit;
  logic              cur_mark;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  new_cnt;
  logic              cnt_we;
  logic              mark_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W-1:0]  cnt_wd;
  logic              mark_wd;

  // second stage: previous bump of the same cell has not reached the read yet
  assign bump     = (op_q == TOP_BUMP);
  assign hit      = fwd_valid_q && (fwd_addr_q == addr_q);
  assign cur_mark = hit ? 1'b1 : rd_mark_q;
  assign cur_cnt  = hit ? fwd_cnt_q : rd_cnt_q;

  always_comb begin
    new_cnt = cur_cnt;
    if (!cur_mark && !(&cur_cnt)) begin
      new_cnt = cur_cnt + 1'b1;
    end
  end

  always_comb begin
    cnt_we  = 1'b0;
    mark_we = 1'b0;
    wr_addr = req_i.addr;
    cnt_wd  = '0;
    mark_wd = 1'b0;
    if (bump) begin
      wr_addr = addr_q;
      cnt_we  = !cur_mark;
      mark_we = !cur_mark;
      cnt_wd  = new_cnt;
      mark_wd = 1'b1;
    end else if (req_i.op == TOP_CLR_ALL) begin
      cnt_we  = 1'b1;
      mark_we = 1'b1;
    end else if (req_i.op == TOP_CLR_MARK) begin
      mark_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wd;
    end
    if (mark_we) begin
      mark_mem[wr_addr] <= mark_wd;
    end
    rd_cnt_q  <= cnt_mem[req_i.addr];
    rd_mark_q <= mark_mem[req_i.addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= TOP_NONE;
      fwd_valid_q <= 1'b0;
    end else begin
      op_q        <= req_i.op;
      fwd_valid_q <= bump;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= req_i.addr;
    fwd_addr_q <= addr_q;
    fwd_cnt_q  <= new_cnt;
  end

  assign rd_cnt_o  = rd_cnt_q;
  assign rd_mark_o = rd_mark_q;

  // the write port is shared: a sweep must never meet a pending bump
  a_no_sweep_on_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump |-> (req_i.op != TOP_CLR_ALL && req_i.op != TOP_CLR_MARK))
    else $error("sweep request collides with a bump write");

  a_fwd_follows_bump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_valid_q |-> $past(op_q == TOP_BUMP))
    else $error("forward register set without a bump");

endmodule
`default_nettype wire

[sv/hrhm_addr_gen.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrhm_addr_gen: mixed-radix cell walker
// one shared multiplier builds the dimension weights and the start address,
// then an odometer steps one cell per cycle with adds only
// ----------------------------------------------------------------------------
module hrhm_addr_gen #(
  parameter int RANK = 3
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   go_i,
  input  logic [RANK-1:0][hrhm_pkg::POS_W-1:0]   starts_i,
  input  logic [hrhm_pkg::BINS_W-1:0]            radix_i,
  output hrhm_pkg::cell_t                        cell_o
);
  import hrhm_pkg::*;

  localparam int DIM_W = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int PROD_W = ADDR_W + BINS_W;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WGT  = 2'd1;
  localparam logic [1:0] PH_BASE = 2'd2;
  localparam logic [1:0] PH_WALK = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic [DIM_W-1:0]  idx_q, idx_d;

  logic [POS_W-1:0]  start_q [RANK];
  logic [POS_W-1:0]  pos_q   [RANK];
  logic [POS_W-1:0]  pos_nx  [RANK];
  logic [ADDR_W-1:0] w_q     [RANK];
  logic [ADDR_W-1:0] s_q     [RANK];
  logic [ADDR_W-1:0] wrun_q;
  logic [ADDR_W-1:0] acc_q;

  logic [ADDR_W-1:0] mul_a;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] acc_nx;
  logic [BINS_W-1:0] rm1;
  logic              carry;
  logic [DIM_W-1:0]  cd;
  logic [ADDR_W-1:0] step_addr;

  // shared multiplier, always by the radix, kept modulo the table depth
  assign mul_a  = (phase_q == PH_WGT) ? wrun_q : acc_q;
  assign prod   = PROD_W'(mul_a) * PROD_W'(radix_i);
  assign acc_nx = prod[ADDR_W-1:0] + ADDR_W'(start_q[idx_q]);
  assign rm1    = radix_i - 1'b1;

  // odometer: first dimension not at its top takes the step
  always_comb begin
    carry = 1'b1;
    cd    = '0;
    for (int d = 0; d < RANK; d++) begin
      pos_nx[d] = pos_q[d];
      if (carry) begin
        if ({1'b0, pos_q[d]} == rm1) begin
          pos_nx[d] = start_q[d];
        end else begin
          pos_nx[d] = pos_q[d] + 1'b1;
          cd        = DIM_W'(d);
          carry     = 1'b0;
        end
      end
    end
    step_addr = s_q[cd] + w_q[cd];
  end

  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (go_i) begin
          phase_d = PH_WGT;
          idx_d   = '0;
        end
      end
      PH_WGT: begin
        if (idx_q == DIM_W'(RANK - 1)) begin
          phase_d = PH_BASE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      PH_BASE: begin
        if (idx_q == '0) begin
          phase_d = PH_WALK;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      PH_WALK: begin
        if (carry) begin
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      PH_IDLE: begin
        if (go_i) begin
          for (int d = 0; d < RANK; d++) begin
            start_q[d] <= starts_i[d];
          end
          wrun_q <= ADDR_W'(1);
          acc_q  <= '0;
        end
      end
      PH_WGT: begin
        w_q[idx_q] <= wrun_q;
        wrun_q     <= prod[ADDR_W-1:0];
      end
      PH_BASE: begin
        acc_q <= acc_nx;
        if (idx_q == '0) begin
          for (int d = 0; d < RANK; d++) begin
            s_q[d]   <= acc_nx;
            pos_q[d] <= start_q[d];
          end
        end
      end
      default: begin
        for (int d = 0; d < RANK; d++) begin
          pos_q[d] <= pos_nx[d];
          if (DIM_W'(d) <= cd) begin
            s_q[d] <= step_addr;
          end
        end
      end
    endcase
  end

  assign cell_o.valid = (phase_q == PH_WALK);
  assign cell_o.last  = carry;
  assign cell_o.addr  = s_q[0];

  a_walk_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_o.valid && !cell_o.last) |=> cell_o.valid)
    else $error("cell walk stopped before its last cell");

  a_go_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i |-> (phase_q == PH_IDLE))
    else $error("walk started while a walk is running");

endmodule
`default_nettype wire
